FILE: rtl/rlpp_pkg.sv
// Shared types, status codes and canvas constants of the rectangle list pixel painter.
package rlpp_pkg;

    localparam int CANVAS_W = 13;
    localparam int COLOR_W  = 24;
    localparam int STATUS_W = 2;

    localparam logic [CANVAS_W-1:0] CANVAS_MAX          = 13'd4096;
    localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RESET  = 13'd640;
    localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RESET = 13'd480;

    localparam logic [7:0] WHITE = 8'd255;
    localparam logic [COLOR_W-1:0] WHITE_RGB = {WHITE, WHITE, WHITE};

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_add;
        logic start_query;
        logic scan;
        logic take_hit;
        logic deliver;
    } rlpp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic query_cmd;
        logic query_quick;
        logic hit;
        logic miss_done;
        logic out_free;
    } rlpp_sts_t;

    // A written dimension of zero is taken as one, anything above the maximum as the maximum.
    function automatic logic [CANVAS_W-1:0] clamp_dim(input logic [CANVAS_W-1:0] v);
        logic [CANVAS_W-1:0] r;
        if (v == '0)
        begin
            r = 13'd1;
        end
        else if (v > CANVAS_MAX)
        begin
            r = CANVAS_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/rlpp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rlpp_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rlpp_ctrl.sv
// Controller state machine that sequences adds, queries and result delivery.
module rlpp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rlpp_pkg::rlpp_sts_t sts,
    output rlpp_pkg::rlpp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.query_cmd == rlpp_pkg::CMD_ADD)
                    begin
                        cmd.start_add = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = sts.query_quick ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else if (sts.miss_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: rtl/rlpp_dp.sv
// Datapath: canvas registers, rectangle table, scan comparator and result registers.
module rlpp_dp #(
    parameter int MAX_RECTS  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    input  logic                    command,
    input  logic [COORD_BITS-1:0]   left_x,
    input  logic [COORD_BITS-1:0]   right_x,
    input  logic [COORD_BITS-1:0]   bottom_y,
    input  logic [COORD_BITS-1:0]   top_y,
    input  logic [7:0]              fill_red,
    input  logic [7:0]              fill_green,
    input  logic [7:0]              fill_blue,
    input  logic [COORD_BITS-1:0]   pixel_col,
    input  logic [COORD_BITS-1:0]   pixel_row,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              out_red,
    output logic [7:0]              out_green,
    output logic [7:0]              out_blue,
    output logic [1:0]              status,
    input  rlpp_pkg::rlpp_cmd_t     cmd,
    output rlpp_pkg::rlpp_sts_t     sts
);

    localparam int IDX_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W  = $clog2(MAX_RECTS + 1);
    localparam int CMP_W  = (COORD_BITS > rlpp_pkg::CANVAS_W) ? COORD_BITS : rlpp_pkg::CANVAS_W;
    localparam int CLR_W  = rlpp_pkg::COLOR_W;
    localparam int WORD_W = 4 * COORD_BITS + CLR_W;

    localparam int TOP_LSB    = CLR_W;
    localparam int BOTTOM_LSB = CLR_W + COORD_BITS;
    localparam int RIGHT_LSB  = CLR_W + 2 * COORD_BITS;
    localparam int LEFT_LSB   = CLR_W + 3 * COORD_BITS;

    logic [rlpp_pkg::CANVAS_W-1:0] width_reg;
    logic [rlpp_pkg::CANVAS_W-1:0] height_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [IDX_W-1:0]              scan_idx_reg;
    logic                          cmp_valid_reg;
    logic                          cmp_last_reg;
    logic [CMP_W-1:0]              col_reg;
    logic [CMP_W-1:0]              y_reg;
    logic [CLR_W-1:0]              res_color_reg;
    logic [1:0]                    res_status_reg;
    logic                          out_valid_reg;
    logic [CLR_W-1:0]              out_color_reg;
    logic [1:0]                    out_status_reg;

    logic                          cfg_write;
    logic                          full;
    logic                          outside;
    logic [CMP_W-1:0]              col_ext;
    logic [CMP_W-1:0]              row_ext;
    logic [CMP_W-1:0]              y_calc;
    logic [CNT_W-1:0]              cnt_m1;
    logic                          ram_we;
    logic [WORD_W-1:0]             ram_wdata;
    logic [WORD_W-1:0]             ram_rdata;
    logic [CMP_W-1:0]              rd_left;
    logic [CMP_W-1:0]              rd_right;
    logic [CMP_W-1:0]              rd_bottom;
    logic [CMP_W-1:0]              rd_top;
    logic                          covers;

    // Configuration registers. Any address maps onto one of the two registers by bit 2.
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rlpp_pkg::CANVAS_WIDTH_RESET;
            height_reg <= rlpp_pkg::CANVAS_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == rlpp_pkg::REG_CANVAS_WIDTH)
            begin
                width_reg <= rlpp_pkg::clamp_dim(pwdata[rlpp_pkg::CANVAS_W-1:0]);
            end
            else
            begin
                height_reg <= rlpp_pkg::clamp_dim(pwdata[rlpp_pkg::CANVAS_W-1:0]);
            end
        end
    end

    assign prdata = (paddr[2] == rlpp_pkg::REG_CANVAS_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    // Query front end: bounds check against the canvas and the flip to a y-up coordinate.
    assign col_ext = CMP_W'(pixel_col);
    assign row_ext = CMP_W'(pixel_row);
    assign outside = (col_ext >= CMP_W'(width_reg)) || (row_ext >= CMP_W'(height_reg));
    assign y_calc  = CMP_W'(height_reg) - CMP_W'(1) - row_ext;
    assign full    = (cnt_reg == CNT_W'(MAX_RECTS));
    assign cnt_m1  = cnt_reg - CNT_W'(1);

    // Rectangle table.
    assign ram_we    = cmd.start_add && !full;
    assign ram_wdata = {left_x, right_x, bottom_y, top_y, fill_red, fill_green, fill_blue};

    rlpp_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_RECTS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cnt_reg[IDX_W-1:0]),
        .wdata(ram_wdata),
        .raddr(scan_idx_reg),
        .rdata(ram_rdata)
    );

    // One comparator set checks the entry read in the previous cycle.
    assign rd_left   = CMP_W'(ram_rdata[LEFT_LSB +: COORD_BITS]);
    assign rd_right  = CMP_W'(ram_rdata[RIGHT_LSB +: COORD_BITS]);
    assign rd_bottom = CMP_W'(ram_rdata[BOTTOM_LSB +: COORD_BITS]);
    assign rd_top    = CMP_W'(ram_rdata[TOP_LSB +: COORD_BITS]);
    assign covers    = (col_reg >= rd_left) && (col_reg <= rd_right)
                    && (y_reg >= rd_bottom) && (y_reg <= rd_top);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.start_query)
            begin
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_valid_reg <= 1'b1;
            end
            if (cmd.deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_add)
        begin
            res_color_reg  <= rlpp_pkg::WHITE_RGB;
            res_status_reg <= full ? rlpp_pkg::STATUS_FULL : rlpp_pkg::STATUS_OK;
        end
        if (cmd.start_query)
        begin
            res_color_reg  <= rlpp_pkg::WHITE_RGB;
            res_status_reg <= outside ? rlpp_pkg::STATUS_OUTSIDE : rlpp_pkg::STATUS_OK;
            col_reg        <= col_ext;
            y_reg          <= y_calc;
            scan_idx_reg   <= cnt_m1[IDX_W-1:0];
        end
        else if (cmd.scan)
        begin
            cmp_last_reg <= (scan_idx_reg == '0);
            if (scan_idx_reg != '0)
            begin
                scan_idx_reg <= scan_idx_reg - IDX_W'(1);
            end
        end
        if (cmd.take_hit)
        begin
            res_color_reg <= ram_rdata[CLR_W-1:0];
        end
        if (cmd.deliver)
        begin
            out_color_reg  <= res_color_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign sts.query_cmd   = command;
    assign sts.query_quick = outside || (cnt_reg == '0);
    assign sts.hit         = cmp_valid_reg && covers;
    assign sts.miss_done   = cmp_valid_reg && cmp_last_reg && !covers;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_red   = out_color_reg[23:16];
    assign out_green = out_color_reg[15:8];
    assign out_blue  = out_color_reg[7:0];
    assign status    = out_status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RECTS))
        else $error("rectangle count exceeds table depth");

    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_add && full) |=> (cnt_reg == $past(cnt_reg)))
        else $error("rejected add changed the rectangle count");

    a_last_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && cmp_valid_reg && cmp_last_reg) |-> (scan_idx_reg == '0))
        else $error("scan ended before reaching the oldest entry");

    a_outside_white: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == rlpp_pkg::STATUS_OUTSIDE)
        |-> (out_color_reg == rlpp_pkg::WHITE_RGB))
        else $error("outside query result is not white");

endmodule

FILE: rtl/rectangle_list_pixel_painter.sv
// Top level of the rectangle list pixel painter: controller, datapath and table.
//
// The block keeps a table of up to MAX_RECTS axis-aligned rectangles, each with inclusive
// bounds (y pointing up) and an RGB fill, and answers pixel queries with the color of the
// newest rectangle that covers the pixel, or white when none does. Every item, add or query,
// gives exactly one result item. An add writes its result into the result registers on
// acceptance and moves it into the output register from the DONE state, after which the
// block returns to IDLE and can take the next item. A full table rejects the add with the
// table-full status. A query outside the canvas, or on an empty table, also goes straight
// to the DONE state. Any other query walks the table newest first through the single read
// port of the rectangle RAM and one comparator set, one entry per cycle with the compare in
// the cycle after the read. The walk stops at the first rectangle that covers the pixel,
// whose color becomes the result, or after the oldest entry, and the result then moves on
// from the DONE state. One item is in work at a time; a new item is taken once the previous
// result has moved into the output register, even if that result is still stalled, and a
// stalled output register adds its stall cycles to the item behind it.
// The canvas width and height registers sit at byte addresses 0 and 4 of the APB-style
// port; a written value keeps its low 13 bits, of which zero reads back as one and a value
// above 4096 as 4096. They should be written only while no item is in work.
module rectangle_list_pixel_painter #(
    parameter int MAX_RECTS  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] bottom_y,
    input  logic [COORD_BITS-1:0] top_y,
    input  logic [7:0]            fill_red,
    input  logic [7:0]            fill_green,
    input  logic [7:0]            fill_blue,
    input  logic [COORD_BITS-1:0] pixel_col,
    input  logic [COORD_BITS-1:0] pixel_row,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic [1:0]            status
);

    rlpp_pkg::rlpp_cmd_t cmd;
    rlpp_pkg::rlpp_sts_t sts;

    // The register port never inserts wait states.
    assign pready = 1'b1;

    // The controller decides what happens in each cycle; it sees only in_valid and the status group.
    rlpp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the table, the canvas registers and the result registers.
    rlpp_dp #(
        .MAX_RECTS (MAX_RECTS),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .command   (command),
        .left_x    (left_x),
        .right_x   (right_x),
        .bottom_y  (bottom_y),
        .top_y     (top_y),
        .fill_red  (fill_red),
        .fill_green(fill_green),
        .fill_blue (fill_blue),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .status    (status),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: tb/rectangle_list_pixel_painter_tb.sv
// Self-checking testbench for the rectangle list pixel painter.
`timescale 1ns / 1ps

module rectangle_list_pixel_painter_tb;

    localparam int MAX_RECTS    = 64;
    localparam int COORD_BITS   = 12;
    localparam int SETTLE_WAIT  = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_STRETCH = 300;

    // One command item as the sender offers it.
    typedef struct {
        logic                  command;
        logic [COORD_BITS-1:0] left_x;
        logic [COORD_BITS-1:0] right_x;
        logic [COORD_BITS-1:0] bottom_y;
        logic [COORD_BITS-1:0] top_y;
        logic [7:0]            fill_red;
        logic [7:0]            fill_green;
        logic [7:0]            fill_blue;
        logic [COORD_BITS-1:0] pixel_col;
        logic [COORD_BITS-1:0] pixel_row;
    } paint_item_t;

    // One answer item of the block.
    typedef struct {
        logic [7:0]                    red;
        logic [7:0]                    green;
        logic [7:0]                    blue;
        logic [rlpp_pkg::STATUS_W-1:0] code;
    } pixel_result_t;

    // The testbench's own copy of one stored rectangle.
    typedef struct {
        int          left;
        int          right;
        int          bottom;
        int          top;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } painted_rect_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [COORD_BITS-1:0] left_x;
    logic [COORD_BITS-1:0] right_x;
    logic [COORD_BITS-1:0] bottom_y;
    logic [COORD_BITS-1:0] top_y;
    logic [7:0]            fill_red;
    logic [7:0]            fill_green;
    logic [7:0]            fill_blue;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic [1:0]            status;

    // Predictor state: the rectangle table, its fill level and the canvas size.
    painted_rect_t rect_table [MAX_RECTS];
    int            rects_stored;
    int            canvas_w;
    int            canvas_h;

    // Answers predicted for accepted items, oldest first.
    pixel_result_t due_pixels [$];
    pixel_result_t oldest_due;

    // Idling controls shared by the sender, the receiver and the test tasks.
    bit tx_idle;
    bit rx_idle;
    int stall_left;
    int hold_cycles;

    int cycle_count;
    int mismatch_count;
    int n_adds;
    int n_rejected;
    int n_queries;
    int n_hits;
    int n_outside;
    int n_settings;

    rectangle_list_pixel_painter #(
        .MAX_RECTS  (MAX_RECTS),
        .COORD_BITS (COORD_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .left_x     (left_x),
        .right_x    (right_x),
        .bottom_y   (bottom_y),
        .top_y      (top_y),
        .fill_red   (fill_red),
        .fill_green (fill_green),
        .fill_blue  (fill_blue),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .status     (status)
    );

    // 250 MHz clock: 2 ns high, 2 ns low.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A hung block must not hang the run. The limit covers about 1100 items at the
    // slowest correct pace (the largest sender gap, a full table scan and the largest
    // receiver stall each), the long hold-off and the drains, several times over.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles, %0d answers still due",
                     $time, cycle_count, due_pixels.size());
            $display("rectangle_list_pixel_painter_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // A written dimension keeps its low 13 bits; zero becomes one and anything above
    // the largest canvas becomes the largest canvas.
    function automatic int limit_dimension(input logic [31:0] value);
        int v;
        v = int'(value[rlpp_pkg::CANVAS_W-1:0]);
        if (v < 1)
        begin
            v = 1;
        end
        else if (v > int'(rlpp_pkg::CANVAS_MAX))
        begin
            v = int'(rlpp_pkg::CANVAS_MAX);
        end
        return v;
    endfunction

    // Works out the answer to one accepted item and applies the item to the table.
    // Queries walk the table newest first, so the latest covering rectangle wins.
    function automatic pixel_result_t predict_pixel(input paint_item_t it);
        pixel_result_t res;
        int            y;
        int            col;
        int            k;
        bit            found;
        res.red   = rlpp_pkg::WHITE;
        res.green = rlpp_pkg::WHITE;
        res.blue  = rlpp_pkg::WHITE;
        res.code  = rlpp_pkg::STATUS_OK;
        if (it.command == rlpp_pkg::CMD_ADD)
        begin
            n_adds = n_adds + 1;
            if (rects_stored >= MAX_RECTS)
            begin
                res.code   = rlpp_pkg::STATUS_FULL;
                n_rejected = n_rejected + 1;
            end
            else
            begin
                rect_table[rects_stored].left   = int'(it.left_x);
                rect_table[rects_stored].right  = int'(it.right_x);
                rect_table[rects_stored].bottom = int'(it.bottom_y);
                rect_table[rects_stored].top    = int'(it.top_y);
                rect_table[rects_stored].red    = it.fill_red;
                rect_table[rects_stored].green  = it.fill_green;
                rect_table[rects_stored].blue   = it.fill_blue;
                rects_stored = rects_stored + 1;
            end
        end
        else
        begin
            n_queries = n_queries + 1;
            col = int'(it.pixel_col);
            if (col >= canvas_w || int'(it.pixel_row) >= canvas_h)
            begin
                res.code  = rlpp_pkg::STATUS_OUTSIDE;
                n_outside = n_outside + 1;
            end
            else
            begin
                // Image rows count down from the top, y counts up from the bottom.
                y     = canvas_h - 1 - int'(it.pixel_row);
                found = 1'b0;
                k     = rects_stored - 1;
                while (!found && k >= 0)
                begin
                    if (col >= rect_table[k].left && col <= rect_table[k].right &&
                        y >= rect_table[k].bottom && y <= rect_table[k].top)
                    begin
                        res.red   = rect_table[k].red;
                        res.green = rect_table[k].green;
                        res.blue  = rect_table[k].blue;
                        found     = 1'b1;
                        n_hits    = n_hits + 1;
                    end
                    k = k - 1;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------------------

    function automatic paint_item_t add_rect(input int l, input int r, input int b,
                                             input int t, input logic [23:0] rgb);
        paint_item_t it;
        it.command    = rlpp_pkg::CMD_ADD;
        it.left_x     = COORD_BITS'(l);
        it.right_x    = COORD_BITS'(r);
        it.bottom_y   = COORD_BITS'(b);
        it.top_y      = COORD_BITS'(t);
        it.fill_red   = rgb[23:16];
        it.fill_green = rgb[15:8];
        it.fill_blue  = rgb[7:0];
        it.pixel_col  = '0;
        it.pixel_row  = '0;
        return it;
    endfunction

    function automatic paint_item_t query_pixel(input int col, input int row);
        paint_item_t it;
        it           = add_rect(0, 0, 0, 0, 24'h0);
        it.command   = rlpp_pkg::CMD_QUERY;
        it.pixel_col = COORD_BITS'(col);
        it.pixel_row = COORD_BITS'(row);
        return it;
    endfunction

    // Random item. Every field is first drawn over its whole range, then the fields that
    // matter are mostly pulled inside the current canvas so that queries land on
    // rectangles. About one add in ten is inverted on one axis and about one in five
    // items keeps its raw full-range coordinates.
    function automatic paint_item_t random_item(input int add_pct);
        paint_item_t it;
        int          a;
        int          b;
        int          c;
        int          d;
        int          pick;
        it.command    = ($urandom_range(0, 99) < add_pct) ? rlpp_pkg::CMD_ADD
                                                          : rlpp_pkg::CMD_QUERY;
        it.left_x     = COORD_BITS'($urandom_range(0, 4095));
        it.right_x    = COORD_BITS'($urandom_range(0, 4095));
        it.bottom_y   = COORD_BITS'($urandom_range(0, 4095));
        it.top_y      = COORD_BITS'($urandom_range(0, 4095));
        it.fill_red   = 8'($urandom_range(0, 255));
        it.fill_green = 8'($urandom_range(0, 255));
        it.fill_blue  = 8'($urandom_range(0, 255));
        it.pixel_col  = COORD_BITS'($urandom_range(0, 4095));
        it.pixel_row  = COORD_BITS'($urandom_range(0, 4095));
        pick = $urandom_range(0, 9);
        if (pick < 8)
        begin
            if (it.command == rlpp_pkg::CMD_ADD)
            begin
                a = $urandom_range(0, canvas_w - 1);
                b = $urandom_range(0, canvas_w - 1);
                c = $urandom_range(0, canvas_h - 1);
                d = $urandom_range(0, canvas_h - 1);
                it.left_x   = COORD_BITS'((a < b) ? a : b);
                it.right_x  = COORD_BITS'((a < b) ? b : a);
                it.bottom_y = COORD_BITS'((c < d) ? c : d);
                it.top_y    = COORD_BITS'((c < d) ? d : c);
                if (pick == 7)
                begin
                    // An inverted rectangle takes a table slot but covers nothing.
                    if ($urandom_range(0, 1) == 1)
                    begin
                        it.left_x  = COORD_BITS'((a < b) ? b : a);
                        it.right_x = COORD_BITS'((a < b) ? a : b);
                    end
                    else
                    begin
                        it.bottom_y = COORD_BITS'((c < d) ? d : c);
                        it.top_y    = COORD_BITS'((c < d) ? c : d);
                    end
                end
            end
            else
            begin
                it.pixel_col = COORD_BITS'($urandom_range(0, canvas_w - 1));
                it.pixel_row = COORD_BITS'($urandom_range(0, canvas_h - 1));
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------------------
    // Sender, receiver and answer checking
    // ------------------------------------------------------------------------------------

    // Offers one item and returns at the rising edge that accepts it. The payload is
    // driven at a falling edge and left untouched while the block stalls. When no gap
    // is drawn, valid simply stays high into the next item.
    task automatic send_item(input paint_item_t it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command    = it.command;
        left_x     = it.left_x;
        right_x    = it.right_x;
        bottom_y   = it.bottom_y;
        top_y      = it.top_y;
        fill_red   = it.fill_red;
        fill_green = it.fill_green;
        fill_blue  = it.fill_blue;
        pixel_col  = it.pixel_col;
        pixel_row  = it.pixel_row;
        in_valid   = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        due_pixels.push_back(predict_pixel(it));
    endtask

    // Lowers valid and waits until every predicted answer has come back. Every item
    // gives an answer and the block works on one item at a time, so once the queue is
    // empty the block is idle; a settling wait follows all the same.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Receiver: a long hold-off, when one is asked for, is counted down here cycle by
    // cycle; otherwise the stall drawn after the last answer is served.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall   = 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else if (stall_left > 0)
            begin
                out_stall  = 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count = mismatch_count + 1;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Every accepted answer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (due_pixels.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                $display("%0t ns: unexpected answer, expected none, actual rgb %h %h %h status %0d",
                         $time, out_red, out_green, out_blue, status);
            end
            else
            begin
                oldest_due = due_pixels.pop_front();
                check_field("out_red", int'(oldest_due.red), int'(out_red));
                check_field("out_green", int'(oldest_due.green), int'(out_green));
                check_field("out_blue", int'(oldest_due.blue), int'(out_blue));
                check_field("status", int'(oldest_due.code), int'(status));
            end
            stall_left = rx_idle ? $urandom_range(0, 17) : 0;
        end
    end

    // ------------------------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------------------------

    task automatic read_canvas_reg(input logic reg_sel);
        int want;
        want = (reg_sel == rlpp_pkg::REG_CANVAS_WIDTH) ? canvas_w : canvas_h;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {reg_sel, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        check_field((reg_sel == rlpp_pkg::REG_CANVAS_WIDTH) ? "canvas width readback"
                                                            : "canvas height readback",
                    want, int'(prdata[rlpp_pkg::CANVAS_W-1:0]));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_canvas_reg(input logic reg_sel, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (reg_sel == rlpp_pkg::REG_CANVAS_WIDTH)
        begin
            canvas_w = limit_dimension(value);
        end
        else
        begin
            canvas_h = limit_dimension(value);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        read_canvas_reg(reg_sel);
    endtask

    // Sets both dimensions and reads them back. Only called while the block is idle.
    task automatic set_canvas(input logic [31:0] w_value, input logic [31:0] h_value);
        write_canvas_reg(rlpp_pkg::REG_CANVAS_WIDTH, w_value);
        write_canvas_reg(rlpp_pkg::REG_CANVAS_HEIGHT, h_value);
        n_settings = n_settings + 1;
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Reset values, then the clamping of zero, of values above the largest canvas and
    // of bits above the 13-bit field.
    task automatic test_register_clamping();
        read_canvas_reg(rlpp_pkg::REG_CANVAS_WIDTH);
        read_canvas_reg(rlpp_pkg::REG_CANVAS_HEIGHT);
        set_canvas(32'd0, 32'd8191);
        set_canvas(32'd4097, 32'hFFFF_E001);
        set_canvas(32'hABCD_0000 | 32'd300, 32'd4096);
    endtask

    // Hand-picked items on a 640 x 480 canvas: empty table, the canvas edges, a
    // rectangle edge from each side, both kinds of inverted rectangle, a one-pixel
    // rectangle and the far corner of the coordinate range.
    task automatic test_directed_painting();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_canvas(32'd640, 32'd480);
        send_item(query_pixel(0, 0));
        send_item(query_pixel(640, 0));
        send_item(query_pixel(0, 480));
        send_item(query_pixel(4095, 4095));
        send_item(add_rect(0, 4095, 0, 4095, 24'h000000));
        send_item(query_pixel(639, 479));
        send_item(query_pixel(0, 0));
        send_item(add_rect(10, 20, 100, 110, 24'h123456));
        // Rows 379 and 369 are y = 100 and y = 110 on this canvas.
        send_item(query_pixel(10, 379));
        send_item(query_pixel(20, 369));
        send_item(query_pixel(9, 370));
        send_item(query_pixel(21, 370));
        send_item(query_pixel(15, 368));
        send_item(query_pixel(15, 380));
        send_item(add_rect(30, 5, 100, 110, 24'hFF0000));
        send_item(add_rect(5, 30, 110, 100, 24'h00FF00));
        send_item(query_pixel(15, 374));
        send_item(add_rect(15, 15, 105, 105, 24'hFEDCBA));
        send_item(query_pixel(15, 374));
        send_item(query_pixel(16, 374));
        send_item(add_rect(4095, 4095, 4095, 4095, 24'hABCDEF));
        drain_results();
    endtask

    // One phase of random traffic at a given canvas setting and idling mix.
    task automatic test_random_traffic(input logic [31:0] w_value, input logic [31:0] h_value,
                                       input int count, input int add_pct,
                                       input bit tx_gaps, input bit rx_gaps);
        set_canvas(w_value, h_value);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        repeat (count) send_item(random_item(add_pct));
        drain_results();
    endtask

    // Fills whatever room is left in the table, then checks that further adds are
    // refused and leave the queries unchanged.
    task automatic test_table_full();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        while (rects_stored < MAX_RECTS)
        begin
            send_item(add_rect($urandom_range(0, 2047), $urandom_range(2048, 4095),
                               $urandom_range(0, 2047), $urandom_range(2048, 4095),
                               24'($urandom)));
        end
        send_item(add_rect(0, 4095, 0, 4095, 24'h00FF00));
        send_item(query_pixel(canvas_w / 2, canvas_h / 2));
        send_item(add_rect(0, 0, 0, 0, 24'hFFFFFF));
        send_item(add_rect(4095, 0, 4095, 0, 24'h000000));
        send_item(query_pixel(0, canvas_h - 1));
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering items
    // back to back, so the output register and the block both fill and the input stalls.
    task automatic test_output_hold();
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_cycles = HOLD_STRETCH;
        repeat (10) send_item(random_item(20));
        drain_results();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        command    = rlpp_pkg::CMD_ADD;
        left_x     = '0;
        right_x    = '0;
        bottom_y   = '0;
        top_y      = '0;
        fill_red   = '0;
        fill_green = '0;
        fill_blue  = '0;
        pixel_col  = '0;
        pixel_row  = '0;

        rects_stored   = 0;
        canvas_w       = int'(rlpp_pkg::CANVAS_WIDTH_RESET);
        canvas_h       = int'(rlpp_pkg::CANVAS_HEIGHT_RESET);
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        stall_left     = 0;
        hold_cycles    = 0;
        cycle_count    = 0;
        mismatch_count = 0;
        n_adds         = 0;
        n_rejected     = 0;
        n_queries      = 0;
        n_hits         = 0;
        n_outside      = 0;
        n_settings     = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_clamping();
        test_directed_painting();
        // The early phases add often enough to bring the table close to full, so that
        // later queries scan long lists.
        test_random_traffic(32'd640, 32'd480, 200, 15, 1'b1, 1'b1);
        test_random_traffic(32'd0, 32'd1, 60, 10, 1'b1, 1'b0);
        test_random_traffic(32'd8191, 32'd4096, 160, 15, 1'b0, 1'b0);
        test_table_full();
        test_output_hold();
        test_random_traffic(32'd4096, 32'd1, 120, 10, 1'b1, 1'b1);
        test_random_traffic(32'd1, 32'd4096, 120, 10, 1'b0, 1'b1);
        test_random_traffic(32'd37, 32'd23, 150, 10, 1'b1, 1'b0);
        test_random_traffic(32'($urandom_range(1, 4096)), 32'($urandom_range(1, 4096)),
                            150, 10, 1'b1, 1'b1);
        test_random_traffic(32'd640, 32'd480, 60, 10, 1'b0, 1'b0);

        repeat (MAX_RECTS + SETTLE_WAIT) @(posedge clk);
        if (due_pixels.size() != 0)
        begin
            mismatch_count = mismatch_count + 1;
            $display("%0t ns: %0d answers never arrived, expected none outstanding",
                     $time, due_pixels.size());
        end

        $display("Run covered %0d adds (%0d refused on a full table) and %0d queries",
                 n_adds, n_rejected, n_queries);
        $display("(%0d painted, %0d off canvas) over %0d canvas settings in %0d cycles.",
                 n_hits, n_outside, n_settings, cycle_count);
        if (mismatch_count == 0)
        begin
            $display("rectangle_list_pixel_painter_tb: clean");
        end
        else
        begin
            $display("rectangle_list_pixel_painter_tb: errors");
        end
        $finish;
    end

endmodule
